[rtl/core/smp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smp_pkg: shared types and constants
// Register indexes, sequencer states and fixed limits of the move controller.
// ----------------------------------------------------------------------------
package smp_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 21;

  localparam logic [CfgIdxW-1:0] RegTarget  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCruise  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRamp    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPGain   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegIGain   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegHGain   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegPwmLim  = 3'd6;

  localparam logic CmdStart = 1'b0;
  localparam logic CmdTick  = 1'b1;

  // square root unit operand width
  localparam int unsigned SqW = 40;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_SQRT_S,
    ST_DIV,
    ST_TICK,
    ST_SQRT_T,
    ST_PI_R,
    ST_PI_L,
    ST_OUT
  } state_e;

endpackage

[rtl/core/smp_isqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smp_isqrt: iterative integer square root
// Truncating root, one result bit per cycle (digit by digit).
// ----------------------------------------------------------------------------
module smp_isqrt
  import smp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SqW-1:0]    x_i,
  output logic              busy_o,
  output logic [SqW/2-1:0]  root_o
);

  localparam int unsigned StepW = $clog2(SqW/2 + 1);

  logic [SqW-1:0]   rem_q, rem_d;
  logic [SqW/2-1:0] root_q, root_d;
  logic [SqW-1:0]   x_q, x_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;

  logic [SqW+1:0]   rem_sh;
  logic [SqW+1:0]   trial;

  // one bit of root per step
  always_comb begin
    rem_sh = {rem_q, x_q[SqW-1 -: 2]};
    trial  = {{(SqW/2){1'b0}}, root_q, 2'b01};
    rem_d  = rem_q;
    root_d = root_q;
    x_d    = x_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = '0;
      root_d = '0;
      x_d    = x_i;
      cnt_d  = StepW'(SqW/2);
      busy_d = 1'b1;
    end else if (busy_q) begin
      x_d = {x_q[SqW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = SqW'(rem_sh - trial);
        root_d = {root_q[SqW/2-2:0], 1'b1};
      end else begin
        rem_d  = SqW'(rem_sh);
        root_d = {root_q[SqW/2-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == StepW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    x_q    <= x_d;
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

[rtl/core/smp_divu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smp_divu: iterative unsigned divider
// Restoring division of a 27 bit dividend by a 12 bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module smp_divu
  import smp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [26:0] num_i,
  input  logic [11:0] den_i,
  output logic        busy_o,
  output logic [26:0] quot_o
);

  logic [26:0] quo_q, quo_d;
  logic [12:0] rem_q, rem_d;
  logic [11:0] den_q, den_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [13:0] rem_sh;

  // shift, compare and subtract each step
  always_comb begin
    rem_sh = {rem_q, quo_q[26]};
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = 5'd27;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {2'b00, den_q}) begin
        rem_d = 13'(rem_sh - {2'b00, den_q});
        quo_d = {quo_q[25:0], 1'b1};
      end else begin
        rem_d = 13'(rem_sh);
        quo_d = {quo_q[25:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == 5'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

[rtl/core/straight_move_profile_pi.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// straight_move_profile_pi: straight-line move profile and wheel PI loops
// Speed profile with sqrt shaped ramps, one PI loop per wheel, heading trim.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake
//  ---------+-----------+-------------------------------------
//  in word  | input     | in_valid_i / in_ready_o
//  out word | output    | out_valid_o / out_ready_i
//  config   | input     | cfg_we_i, cfg_idx_i, cfg_data_i
//
// A start word runs the square root unit (short move) or the divider; a
// tick word runs the square root unit on a ramp, then two PI steps, or only
// the two PI steps in the cruise zone. One word at a time: in_ready_o is
// low from acceptance until the result word is taken.
// Reset restores the register defaults and clears the integrators and spans.
// ----------------------------------------------------------------------------
module straight_move_profile_pi
  import smp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                command_i,
  input  logic signed [20:0]  right_travel_i,
  input  logic signed [20:0]  left_travel_i,
  input  logic signed [12:0]  right_velocity_i,
  input  logic signed [12:0]  left_velocity_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [15:0]  pwm_right_o,
  output logic signed [15:0]  pwm_left_o,
  output logic signed [12:0]  speed_reference_o,
  output logic                move_done_o
);

  localparam logic signed [39:0] IntMax = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] IntMin = {1'b1, {39{1'b0}}};

  // configuration registers
  logic signed [20:0] target_q;
  logic [11:0] cruise_q, ramp_q;
  logic [15:0] pgain_q, igain_q;
  logic [7:0]  hgain_q;
  logic [14:0] plim_q;

  // state
  logic signed [39:0] integ_r_q, integ_r_d, integ_l_q, integ_l_d;
  logic [20:0] span_q, span_d;
  logic [11:0] eff_q, eff_d;
  state_e state_q, state_d;

  // captured word
  logic signed [20:0] rt_q, lt_q;
  logic signed [12:0] rv_q, lv_q;

  // tick working registers
  logic signed [12:0] ref_q, ref_d;
  logic               neg_q, neg_d;
  logic [1:0]         zone_q, zone_d;   // 0 accel, 1 decel, 2 cruise
  logic               done_q, done_d;
  logic signed [15:0] pr_q, pr_d, pl_q, pl_d;
  logic               valid_q, valid_d;

  // shared unit handshakes
  logic sq_start, sq_busy, dv_start, dv_busy;
  logic [SqW-1:0] sq_x;
  logic [SqW/2-1:0] sq_root;
  logic [26:0] dv_num, dv_quot;
  logic [11:0] ramp_u;

  assign ramp_u = (ramp_q == 12'd0) ? 12'd1 : ramp_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      cruise_q <= '0;
      ramp_q   <= 12'd400;
      pgain_q  <= 16'd2560;
      igain_q  <= 16'd294;
      hgain_q  <= 8'd25;
      plim_q   <= 15'd1000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegTarget: target_q <= signed'(cfg_data_i);
        RegCruise: cruise_q <= cfg_data_i[11:0];
        RegRamp:   ramp_q   <= cfg_data_i[11:0];
        RegPGain:  pgain_q  <= cfg_data_i[15:0];
        RegIGain:  igain_q  <= cfg_data_i[15:0];
        RegHGain:  hgain_q  <= cfg_data_i[7:0];
        RegPwmLim: plim_q   <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // start arithmetic
  logic [20:0] dabs;
  logic [23:0] sq_c;
  logic [32:0] d_ramp;
  logic        short_mv;
  logic [19:0] half_d;
  logic [31:0] sp_prod;
  assign dabs     = target_q[20] ? 21'(-target_q) : 21'(target_q);
  assign sq_c     = cruise_q * cruise_q;
  assign d_ramp   = dabs * ramp_u;
  assign short_mv = d_ramp < {5'd0, sq_c, 4'd0};
  assign half_d   = dabs[20:1];
  assign sp_prod  = ramp_u * half_d;

  // tick arithmetic
  logic signed [21:0] s_sum;
  logic signed [22:0] dist2;
  logic [21:0] as_abs;
  logic [22:0] ds_abs;
  logic [22:0] az_sel;
  logic [34:0] prod_r;
  assign s_sum  = 22'(rt_q) + 22'(lt_q);
  assign dist2  = 23'(s_sum) - 23'(signed'({target_q, 1'b0}));
  assign as_abs = s_sum[21] ? 22'(-s_sum) : 22'(s_sum);
  assign ds_abs = dist2[22] ? 23'(-dist2) : 23'(dist2);
  assign az_sel = (zone_d == 2'd0) ? {1'b0, as_abs} : ds_abs;
  assign prod_r = az_sel * ramp_u;

  // square root operand; (2*ramp*span)>>4 is (ramp*span)>>3
  always_comb begin
    if (state_q == ST_START) sq_x = SqW'(sp_prod >> 3);
    else                     sq_x = SqW'(prod_r >> 4);
  end

  assign dv_num = {sq_c, 3'b000};

  smp_isqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .x_i    (sq_x),
    .busy_o (sq_busy),
    .root_o (sq_root)
  );

  smp_divu u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dv_start),
    .num_i  (dv_num),
    .den_i  (ramp_u),
    .busy_o (dv_busy),
    .quot_o (dv_quot)
  );

  // PI step, shared by both wheels
  logic               pi_left;
  logic signed [12:0] pi_v;
  logic signed [39:0] pi_int;
  logic signed [14:0] err;
  logic signed [40:0] int_sum;
  logic signed [39:0] int_new;
  logic signed [31:0] p_term;
  logic signed [56:0] i_term;
  logic signed [57:0] acc;
  logic signed [49:0] acc_div;
  logic signed [49:0] lim;
  logic signed [15:0] pi_out;
  logic signed [21:0] tdiff;
  logic signed [30:0] corr_p;
  logic signed [26:0] corr;
  logic signed [27:0] pwm_x;
  logic signed [15:0] pwm_sat;

  assign pi_left = (state_q == ST_PI_L);
  assign pi_v    = pi_left ? lv_q : rv_q;
  assign pi_int  = pi_left ? integ_l_q : integ_r_q;
  assign err     = 15'(ref_q) - 15'(pi_v);
  assign int_sum = 41'(pi_int) + 41'(err);
  assign int_new = (int_sum > 41'(IntMax)) ? IntMax :
                   (int_sum < 41'(IntMin)) ? IntMin : 40'(int_sum);
  assign p_term  = signed'({1'b0, pgain_q}) * 32'(err);
  assign i_term  = signed'({1'b0, igain_q}) * int_new;
  assign acc     = 58'(p_term) + 58'(i_term);
  // truncate toward zero
  assign acc_div = 50'((acc + (acc[57] ? 58'sd255 : 58'sd0)) >>> 8);
  assign lim     = 50'(signed'({1'b0, plim_q}));
  assign pi_out  = (acc_div > lim) ? 16'(lim) :
                   (acc_div < -lim) ? 16'(-lim) : 16'(acc_div);
  assign tdiff   = 22'(rt_q) - 22'(lt_q);
  assign corr_p  = signed'({1'b0, hgain_q}) * 31'(tdiff);
  assign corr    = 27'((corr_p + (corr_p[30] ? 31'sd15 : 31'sd0)) >>> 4);
  assign pwm_x   = pi_left ? 28'(pi_out) + 28'(corr) : 28'(pi_out) - 28'(corr);
  assign pwm_sat = (pwm_x > 28'sd32767) ? 16'sd32767 :
                   (pwm_x < -28'sd32768) ? -16'sd32768 : 16'(pwm_x);

  // profile reference from root
  logic [12:0] ref_mag;
  always_comb begin
    if (zone_q == 2'd0)
      ref_mag = (sq_root < 20'd50) ? 13'd50 : (sq_root > 20'd1050) ? 13'd1050 : 13'(sq_root);
    else
      ref_mag = (sq_root < 20'd10) ? 13'd10 : (sq_root > 20'd1010) ? 13'd1010 : 13'(sq_root);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = (command_i == CmdStart) ? ST_START : ST_TICK;
      ST_START:  state_d = short_mv ? ST_SQRT_S : ST_DIV;
      ST_SQRT_S: if (!sq_busy) state_d = ST_OUT;
      ST_DIV:    if (!dv_busy) state_d = ST_OUT;
      ST_TICK:   state_d = (zone_d == 2'd2) ? ST_PI_R : ST_SQRT_T;
      ST_SQRT_T: if (!sq_busy) state_d = ST_PI_R;
      ST_PI_R:   state_d = ST_PI_L;
      ST_PI_L:   state_d = ST_OUT;
      ST_OUT:    if (out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    sq_start  = 1'b0;
    dv_start  = 1'b0;
    integ_r_d = integ_r_q;
    integ_l_d = integ_l_q;
    span_d    = span_q;
    eff_d     = eff_q;
    ref_d     = ref_q;
    neg_d     = neg_q;
    zone_d    = zone_q;
    done_d    = done_q;
    pr_d      = pr_q;
    pl_d      = pl_q;
    valid_d   = 1'b0;
    case (state_q)
      ST_START: begin
        integ_r_d = '0;
        integ_l_d = '0;
        pr_d = '0; pl_d = '0; ref_d = '0; done_d = 1'b0;
        if (short_mv) begin
          span_d   = {1'b0, half_d};
          sq_start = 1'b1;
        end else begin
          dv_start = 1'b1;
        end
      end
      ST_SQRT_S: if (!sq_busy) begin
        eff_d   = (sq_root > 20'd4095) ? 12'd4095 : sq_root[11:0];
        valid_d = 1'b1;
      end
      ST_DIV: if (!dv_busy) begin
        span_d  = (dv_quot > 27'd2097151) ? 21'h1FFFFF : dv_quot[20:0];
        eff_d   = cruise_q;
        valid_d = 1'b1;
      end
      ST_TICK: begin
        neg_d  = !dist2[22];
        done_d = ds_abs <= 23'd32;
        if (as_abs < {span_q, 1'b0})      zone_d = 2'd0;
        else if (ds_abs < {1'b0, span_q, 1'b0}) zone_d = 2'd1;
        else                               zone_d = 2'd2;
        if (zone_d == 2'd2) ref_d = neg_d ? -13'(signed'({1'b0, eff_q})) : 13'(signed'({1'b0, eff_q}));
      end
      ST_SQRT_T: if (!sq_busy) ref_d = neg_q ? 13'(-ref_mag) : ref_mag;
      ST_PI_R: begin
        integ_r_d = int_new;
        pr_d      = pwm_sat;
      end
      ST_PI_L: begin
        integ_l_d = int_new;
        pl_d      = pwm_sat;
        valid_d   = 1'b1;
      end
      ST_OUT: valid_d = !out_ready_i;
      default: ;
    endcase
    if (state_q == ST_TICK && zone_d != 2'd2) sq_start = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      integ_r_q <= '0;
      integ_l_q <= '0;
      span_q    <= '0;
      eff_q     <= '0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      integ_r_q <= integ_r_d;
      integ_l_q <= integ_l_d;
      span_q    <= span_d;
      eff_q     <= eff_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      rt_q  <= right_travel_i;
      lt_q  <= left_travel_i;
      rv_q  <= right_velocity_i;
      lv_q  <= left_velocity_i;
    end
    ref_q  <= ref_d;
    neg_q  <= neg_d;
    zone_q <= zone_d;
    done_q <= done_d;
    pr_q   <= pr_d;
    pl_q   <= pl_d;
  end

  assign in_ready_o        = (state_q == ST_IDLE);
  assign out_valid_o       = valid_q && (state_q == ST_OUT);
  assign pwm_right_o       = pr_q;
  assign pwm_left_o        = pl_q;
  assign speed_reference_o = ref_q;
  assign move_done_o       = done_q;

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for straight_move_profile_pi
// Sends start and tick words through the valid/ready input and checks every
// result word against a local model of the speed profile and wheel PI loops.
// Moves are mostly well-formed (start, then travel walking to the target),
// with random noise words, random idling on both sides and register changes
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb
  import smp_pkg::*;
;

  typedef struct {
    logic               cmd;
    logic signed [20:0] rt;
    logic signed [20:0] lt;
    logic signed [12:0] rv;
    logic signed [12:0] lv;
  } move_word_t;

  typedef struct {
    logic signed [15:0] pr;
    logic signed [15:0] pl;
    logic signed [12:0] sr;
    logic               dn;
  } drive_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                command_i = CmdStart;
  logic signed [20:0]  right_travel_i = '0;
  logic signed [20:0]  left_travel_i = '0;
  logic signed [12:0]  right_velocity_i = '0;
  logic signed [12:0]  left_velocity_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic signed [15:0]  pwm_right_o;
  logic signed [15:0]  pwm_left_o;
  logic signed [12:0]  speed_reference_o;
  logic                move_done_o;

  straight_move_profile_pi dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // register copy and controller state of the model
  longint          m_target;
  longint unsigned m_cruise, m_ramp, m_pgain, m_igain, m_hgain, m_plim;
  longint          m_int_r, m_int_l;
  longint unsigned m_accel, m_decel, m_eff;

  move_word_t word_q[$];
  drive_t     drive_q[$];
  move_word_t cur_word;
  int         errors = 0;
  int         send_gap = 0;
  int         stall = 0;
  int         hold_cnt = 0;
  bit         hold_req = 1'b0;
  bit         quiet = 1'b0;

  function automatic longint unsigned int_root(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // one wheel PI step, integrator saturates at 40 bit limits
  function automatic longint wheel_loop(inout longint integ, input longint err);
    longint acc;
    integ = clip(integ + err, -(64'sd1 <<< 39), (64'sd1 <<< 39) - 1);
    acc = (longint'(m_pgain) * err + longint'(m_igain) * integ) / 256;
    return clip(acc, -longint'(m_plim), longint'(m_plim));
  endfunction

  // model of one accepted word; pushes the drive word it yields
  function automatic void move_step(move_word_t w);
    longint unsigned ramp, d, sq, span, as_v, ds_v, r;
    longint s, dist2, ref_v, corr, pr, pl;
    drive_t e;
    ramp = (m_ramp == 0) ? 1 : m_ramp;
    if (w.cmd == CmdStart) begin
      d = (m_target < 0) ? -m_target : m_target;
      sq = m_cruise * m_cruise;
      m_int_r = 0;
      m_int_l = 0;
      if (d * ramp < 16 * sq) begin
        span = d / 2;
        m_accel = span;
        m_decel = span;
        m_eff = int_root((2 * ramp * span) >> 4);
        if (m_eff > 4095) m_eff = 4095;
      end else begin
        span = (8 * sq) / ramp;
        if (span > 2097151) span = 2097151;
        m_accel = span;
        m_decel = span;
        m_eff = m_cruise;
      end
      e = '{pr: '0, pl: '0, sr: '0, dn: 1'b0};
    end else begin
      s = longint'(w.rt) + longint'(w.lt);
      dist2 = s - 2 * m_target;
      as_v = (s < 0) ? -s : s;
      ds_v = (dist2 < 0) ? -dist2 : dist2;
      if (as_v < 2 * m_accel) begin
        r = int_root((ramp * as_v) >> 4);
        ref_v = 50 + clip(longint'(r) - 50, 0, 1000);
      end else if (ds_v < 2 * m_decel) begin
        r = int_root((ramp * ds_v) >> 4);
        ref_v = 10 + clip(longint'(r) - 10, 0, 1000);
      end else begin
        ref_v = longint'(m_eff);
      end
      if (dist2 >= 0) ref_v = -ref_v;
      pr = wheel_loop(m_int_r, ref_v - longint'(w.rv));
      pl = wheel_loop(m_int_l, ref_v - longint'(w.lv));
      corr = (longint'(m_hgain) * (longint'(w.rt) - longint'(w.lt))) / 16;
      pr = clip(pr - corr, -32768, 32767);
      pl = clip(pl + corr, -32768, 32767);
      e.pr = pr[15:0];
      e.pl = pl[15:0];
      e.sr = ref_v[12:0];
      e.dn = (ds_v <= 32);
    end
    drive_q.push_back(e);
  endfunction

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) move_step(cur_word);
      if (in_valid_i && !in_ready_o) begin
        // word still waiting, hold it
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (word_q.size() > 0 && !quiet && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 12);
        in_valid_i <= 1'b0;
      end else if (word_q.size() > 0) begin
        cur_word = word_q.pop_front();
        in_valid_i       <= 1'b1;
        command_i        <= cur_word.cmd;
        right_travel_i   <= cur_word.rt;
        left_travel_i    <= cur_word.lt;
        right_velocity_i <= cur_word.rv;
        left_velocity_i  <= cur_word.lv;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    drive_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (drive_q.size() == 0) begin
          $display("%0t: result word with none expected", $time);
          errors++;
        end else begin
          e = drive_q.pop_front();
          if (pwm_right_o !== e.pr) begin
            $display("%0t: pwm_right exp %0d got %0d", $time, e.pr, pwm_right_o);
            errors++;
          end
          if (pwm_left_o !== e.pl) begin
            $display("%0t: pwm_left exp %0d got %0d", $time, e.pl, pwm_left_o);
            errors++;
          end
          if (speed_reference_o !== e.sr) begin
            $display("%0t: speed_reference exp %0d got %0d", $time, e.sr,
                     speed_reference_o);
            errors++;
          end
          if (move_done_o !== e.dn) begin
            $display("%0t: move_done exp %0b got %0b", $time, e.dn, move_done_o);
            errors++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(0, 12);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic reg_write(logic [CfgIdxW-1:0] idx, longint val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[CfgDataW-1:0];
    case (idx)
      RegTarget: m_target = longint'($signed(val[20:0]));
      RegCruise: m_cruise = val[11:0];
      RegRamp:   m_ramp = val[11:0];
      RegPGain:  m_pgain = val[15:0];
      RegIGain:  m_igain = val[15:0];
      RegHGain:  m_hgain = val[7:0];
      RegPwmLim: m_plim = val[14:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_word(logic c, longint rt, longint lt, longint rv, longint lv);
    move_word_t w;
    w.cmd = c;
    w.rt = rt[20:0];
    w.lt = lt[20:0];
    w.rv = rv[12:0];
    w.lv = lv[12:0];
    word_q.push_back(w);
  endtask

  // sampled away from the rising edge so driver and monitor have settled
  task automatic wait_idle();
    do @(negedge clk_i);
    while (word_q.size() != 0 || in_valid_i || drive_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic longint pick(longint lo, longint hi);
    int k;
    k = $urandom_range(0, 7);
    if (k == 0) return lo;
    if (k == 1) return hi;
    return lo + longint'($urandom_range(0, 32'(hi - lo)));
  endfunction

  // a start followed by travel walking to the target
  task automatic queue_move(int n);
    longint mean, dv;
    push_word(CmdStart, $urandom, $urandom, $urandom, $urandom);
    for (int k = 0; k <= n; k++) begin
      mean = (m_target * k) / n;
      if (k == n) mean += $signed($urandom_range(0, 40)) - 20;
      dv = $signed($urandom_range(0, 100)) - 50;
      push_word(CmdTick, clip(mean + dv, -1048576, 1048575),
                clip(mean - dv, -1048576, 1048575),
                $signed($urandom_range(0, 2400)) - 1200,
                $signed($urandom_range(0, 2400)) - 1200);
    end
  endtask

  initial begin
    int sent;
    int n;
    m_target = 0; m_cruise = 0; m_ramp = 400; m_pgain = 2560;
    m_igain = 294; m_hgain = 25; m_plim = 1000;
    m_int_r = 0; m_int_l = 0; m_accel = 0; m_decel = 0; m_eff = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // ticks with no start yet, then field extremes
    push_word(CmdTick, 1048575, -1048576, 4095, -4096);
    push_word(CmdTick, -1048576, 1048575, -4096, 4095);
    push_word(CmdTick, 0, 0, 0, 0);
    push_word(CmdStart, -1, -1, -1, -1);
    push_word(CmdTick, 1048575, 1048575, 4095, 4095);
    push_word(CmdTick, -1048576, -1048576, -4096, -4096);
    wait_idle();
    // maximum target move, full gains and limit, zero ramp treated as one
    reg_write(RegTarget, 1048575);
    reg_write(RegCruise, 4095);
    reg_write(RegRamp, 0);
    reg_write(RegPGain, 65535);
    reg_write(RegIGain, 65535);
    reg_write(RegHGain, 255);
    reg_write(RegPwmLim, 32767);
    queue_move(6);
    wait_idle();
    reg_write(RegTarget, -1048576);
    reg_write(RegRamp, 4095);
    reg_write(RegPwmLim, 0);
    reg_write(RegPGain, 0);
    reg_write(RegIGain, 0);
    reg_write(RegHGain, 0);
    reg_write(RegCruise, 0);
    queue_move(5);
    wait_idle();

    // random phases
    sent = 0;
    while (sent < 1850) begin
      if (sent > 1600) quiet = 1'b1;
      reg_write(RegTarget, pick(-1048576, 1048575) >>> $urandom_range(0, 8));
      reg_write(RegCruise, pick(0, 4095));
      reg_write(RegRamp, pick(0, 4095));
      reg_write(RegPGain, pick(0, 65535));
      reg_write(RegIGain, pick(0, 65535) >> $urandom_range(0, 6));
      reg_write(RegHGain, pick(0, 255));
      reg_write(RegPwmLim, pick(0, 32767));
      if ($urandom_range(0, 4) != 0) begin
        n = $urandom_range(8, 50);
        queue_move(n);
        sent += n + 2;
      end else begin
        n = $urandom_range(5, 30);
        for (int i = 0; i < n; i++)
          push_word($urandom_range(0, 3) == 0 ? CmdStart : CmdTick,
                    $signed($urandom) >>> $urandom_range(0, 11),
                    $signed($urandom) >>> $urandom_range(0, 11),
                    $urandom, $urandom);
        sent += n;
      end
      // long receiver holds while words keep coming (phases ending at 601 to 699 words sent)
      if (sent > 600 && sent < 700) hold_req = 1'b1;
      wait_idle();
    end

    repeat (60) @(posedge clk_i);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #8ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
